@@ hdl/button_debounce_click_classifier_unit_macros.svh @@
// Assertion macros used by the core RTL file of the click classifier.
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDCC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdcc assertion failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define BDCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdcc assertion failed (next cycle)");

`endif

@@ hdl/bdcc_pkg.sv @@
// Package with types, codes and helpers of the button click classifier.
`timescale 1ns / 1ps
package bdcc_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int NOW_WIDTH  = 32;
  localparam int CFG_WIDTH  = 16;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd40;
  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET   = 16'd350;
  localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 16'd1000;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CFG_WIDTH-1:0]  cfg_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_INIT   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_WINDOW   = 2'd1,
    CFG_LONG     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    op_t   op;
    logic  raw;
    time_t now;
  } item_t;

  typedef struct packed {
    event_t ev;
    logic   level;
  } result_t;

  // Wrap-around elapsed time.
  function automatic time_t elapsed(time_t now, time_t since);
    return now - since;
  endfunction

  function automatic time_t widen(cfg_t value);
    return {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, value};
  endfunction

endpackage

@@ hdl/bdcc_in_stage.sv @@
// Input register of the click classifier.
`timescale 1ns / 1ps
module bdcc_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bdcc_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output bdcc_pkg::item_t item
);
  import bdcc_pkg::*;

  logic  vld;
  item_t item_q;

  assign in_ready   = !vld || advance;
  assign item_valid = vld;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= in_item;
    end
  end

endmodule

@@ hdl/bdcc_core.sv @@
// Debounce state, click classification and configuration registers.
`timescale 1ns / 1ps
module bdcc_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bdcc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [bdcc_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                 fire,
  input  bdcc_pkg::item_t                      item,
  output bdcc_pkg::result_t                    result
);
  import bdcc_pkg::*;
  `include "button_debounce_click_classifier_unit_macros.svh"

  cfg_t debounce_time, double_click_window, long_press_time;

  logic  candidate_level, stable_level, armed_flag, press_active_flag;
  logic  long_done_flag, click_waiting_flag, second_press_flag;
  time_t candidate_start_time, press_start_time, first_release_time;

  logic  candidate_level_next, stable_level_next, armed_flag_next, press_active_flag_next;
  logic  long_done_flag_next, click_waiting_flag_next, second_press_flag_next;
  time_t candidate_start_time_next, press_start_time_next, first_release_time_next;
  event_t ev;
  logic  stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time       <= DEBOUNCE_RESET;
      double_click_window <= WINDOW_RESET;
      long_press_time     <= LONG_RESET;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: debounce_time       <= cfg_data;
        CFG_WINDOW:   double_click_window <= cfg_data;
        CFG_LONG:     long_press_time     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    candidate_level_next      = candidate_level;
    stable_level_next         = stable_level;
    armed_flag_next           = armed_flag;
    press_active_flag_next    = press_active_flag;
    long_done_flag_next       = long_done_flag;
    click_waiting_flag_next   = click_waiting_flag;
    second_press_flag_next    = second_press_flag;
    candidate_start_time_next = candidate_start_time;
    press_start_time_next     = press_start_time;
    first_release_time_next   = first_release_time;
    ev   = EV_NONE;
    stop = 1'b0;

    if (item.op == OP_INIT) begin
      candidate_level_next      = item.raw;
      stable_level_next         = item.raw;
      armed_flag_next           = !item.raw;
      press_active_flag_next    = 1'b0;
      long_done_flag_next       = 1'b0;
      click_waiting_flag_next   = 1'b0;
      second_press_flag_next    = 1'b0;
      candidate_start_time_next = item.now;
      press_start_time_next     = item.now;
      first_release_time_next   = item.now;
    end else begin
      if (item.raw != candidate_level) begin
        candidate_level_next      = item.raw;
        candidate_start_time_next = item.now;
      end

      if (candidate_level_next != stable_level &&
          elapsed(item.now, candidate_start_time_next) >= widen(debounce_time)) begin
        stable_level_next = candidate_level_next;
        if (!armed_flag) begin
          // Disarmed key: only a stable release re-arms, and it reports nothing.
          if (!candidate_level_next) begin
            armed_flag_next         = 1'b1;
            click_waiting_flag_next = 1'b0;
            second_press_flag_next  = 1'b0;
          end
          stop = 1'b1;
        end else if (candidate_level_next) begin
          press_active_flag_next = 1'b1;
          press_start_time_next  = item.now;
          long_done_flag_next    = 1'b0;
          if (click_waiting_flag) begin
            if (elapsed(candidate_start_time_next, first_release_time) <=
                widen(double_click_window)) begin
              second_press_flag_next = 1'b1;
            end else begin
              // Late second press: flush the waiting click, start over.
              click_waiting_flag_next = 1'b0;
              second_press_flag_next  = 1'b0;
              ev   = EV_SINGLE;
              stop = 1'b1;
            end
          end
        end else begin
          press_active_flag_next = 1'b0;
          if (long_done_flag) begin
            long_done_flag_next    = 1'b0;
            second_press_flag_next = 1'b0;
            stop = 1'b1;
          end else if (second_press_flag) begin
            click_waiting_flag_next = 1'b0;
            second_press_flag_next  = 1'b0;
            ev   = EV_DOUBLE;
            stop = 1'b1;
          end else begin
            click_waiting_flag_next = 1'b1;
            first_release_time_next = item.now;
          end
        end
      end

      if (!stop) begin
        if (armed_flag_next && stable_level_next && press_active_flag_next &&
            !long_done_flag_next &&
            elapsed(item.now, press_start_time_next) >= widen(long_press_time)) begin
          long_done_flag_next     = 1'b1;
          click_waiting_flag_next = 1'b0;
          second_press_flag_next  = 1'b0;
          ev = EV_LONG;
        end else if (click_waiting_flag_next && !stable_level_next && !candidate_level_next &&
                     elapsed(item.now, first_release_time_next) >=
                     widen(double_click_window)) begin
          click_waiting_flag_next = 1'b0;
          ev = EV_SINGLE;
        end
      end
    end
  end

  assign result.ev    = ev;
  assign result.level = stable_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_level      <= 1'b0;
      stable_level         <= 1'b0;
      armed_flag           <= 1'b1;
      press_active_flag    <= 1'b0;
      long_done_flag       <= 1'b0;
      click_waiting_flag   <= 1'b0;
      second_press_flag    <= 1'b0;
      candidate_start_time <= '0;
      press_start_time     <= '0;
      first_release_time   <= '0;
    end else if (fire) begin
      candidate_level      <= candidate_level_next;
      stable_level         <= stable_level_next;
      armed_flag           <= armed_flag_next;
      press_active_flag    <= press_active_flag_next;
      long_done_flag       <= long_done_flag_next;
      click_waiting_flag   <= click_waiting_flag_next;
      second_press_flag    <= second_press_flag_next;
      candidate_start_time <= candidate_start_time_next;
      press_start_time     <= press_start_time_next;
      first_release_time   <= first_release_time_next;
    end
  end

  `BDCC_ASSERT_NOW(a_second_needs_wait, clk, rst, second_press_flag, click_waiting_flag)
  `BDCC_ASSERT_NOW(a_disarmed_no_press, clk, rst, !armed_flag, !press_active_flag)
  `BDCC_ASSERT_NEXT(a_long_sets_done, clk, rst, fire && ev == EV_LONG, long_done_flag && stable_level)
  `BDCC_ASSERT_NEXT(a_double_clears, clk, rst, fire && ev == EV_DOUBLE, !click_waiting_flag && !second_press_flag && !stable_level)

endmodule

@@ hdl/bdcc_out_stage.sv @@
// Result register of the click classifier.
`timescale 1ns / 1ps
module bdcc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bdcc_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output bdcc_pkg::result_t out_res
);
  import bdcc_pkg::*;

  logic    vld;
  result_t res_q;

  assign free      = !vld || out_ready;
  assign out_valid = vld;
  assign out_res   = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (free) begin
      vld <= load;
    end
  end

  // Hold the beat until taken.
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

@@ hdl/button_debounce_click_classifier_unit.sv @@
// An accepted beat waits in the input register; its result is then held in the result register.
// Throughput: one item per cycle when not stalled; the only loop is the core state update.
// The result register frees while the consumer takes its beat, so stalls cost no bubbles.
// Reset: synchronous, active high; clears both valid flags, loads the debounce state
// with its reset values and the three time registers with 40, 350 and 1000 ms.
`timescale 1ns / 1ps
module button_debounce_click_classifier_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic                               raw_level,
  input  logic [bdcc_pkg::NOW_WIDTH-1:0]     now_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         event_res,
  output logic                               pressed_level,
  input  logic                               cfg_write,
  input  logic [bdcc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [bdcc_pkg::CFG_WIDTH-1:0]     cfg_data
);
  import bdcc_pkg::*;

  item_t   in_item, item;
  logic    item_valid, advance, out_free;
  result_t result, out_res;

  assign in_item.op  = op_t'(operation);
  assign in_item.raw = raw_level;
  assign in_item.now = now_ms[TIME_WIDTH-1:0];

  assign advance = item_valid && out_free;

  bdcc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bdcc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (item),
    .result    (result)
  );

  bdcc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign event_res     = out_res.ev;
  assign pressed_level = out_res.level;

endmodule
